// ===== hdl/tsu_pkg.sv =====
`timescale 1ns / 1ps

package tsu_pkg;

    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int PHASE_W  = 3;
    localparam int CLASS_W  = 3;
    localparam int PEND_W   = 2;
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 16;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_QUOTING   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_UNESCAPED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ESC_END   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TRUNC_U   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NONCANON  = 3'd5;
    localparam logic [STATUS_W-1:0] ST_UNSUPP    = 3'd6;
    localparam logic [STATUS_W-1:0] ST_UTF8      = 3'd7;

    localparam logic [PHASE_W-1:0] PH_TEXT = 3'd0;
    localparam logic [PHASE_W-1:0] PH_ESC  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_HEX1 = 3'd2;
    localparam logic [PHASE_W-1:0] PH_HEX2 = 3'd3;
    localparam logic [PHASE_W-1:0] PH_HEX3 = 3'd4;
    localparam logic [PHASE_W-1:0] PH_HEX4 = 3'd5;

    localparam logic [CLASS_W-1:0] CL_ANY  = 3'd0;
    localparam logic [CLASS_W-1:0] CL_A0BF = 3'd1;
    localparam logic [CLASS_W-1:0] CL_809F = 3'd2;
    localparam logic [CLASS_W-1:0] CL_90BF = 3'd3;
    localparam logic [CLASS_W-1:0] CL_808F = 3'd4;

    localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
    localparam logic [BYTE_W-1:0] CH_BSL   = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_DEL   = 8'h7F;

    typedef struct packed {
        logic                 kind;
        logic [BYTE_W-1:0]    data_byte;
        logic [STATUS_W-1:0]  status;
    } result_t;

    typedef struct packed {
        logic [PEND_W-1:0]   pend;
        logic [CLASS_W-1:0]  cls;
        logic                bad;
    } u8_state_t;

    function automatic logic [4:0] hex_digit(input logic [BYTE_W-1:0] b);
        logic [4:0] v;
        v = 5'd16;
        if (b >= 8'h30 && b <= 8'h39)
        begin
            v = {1'b0, b[3:0]};
        end
        else if (b >= 8'h61 && b <= 8'h66)
        begin
            v = {1'b0, b[3:0] + 4'd9};
        end
        return v;
    endfunction

    function automatic u8_state_t u8_feed(input u8_state_t s, input logic [BYTE_W-1:0] b);
        u8_state_t  n;
        logic [BYTE_W-1:0] lo;
        logic [BYTE_W-1:0] hi;
        n  = s;
        lo = 8'h80;
        hi = 8'hBF;
        if (!s.bad)
        begin
            if (s.pend == '0)
            begin
                if (b < 8'h80)
                begin
                    n = s;
                end
                else if (b >= 8'hC2 && b <= 8'hDF)
                begin
                    n.pend = 2'd1;
                    n.cls  = CL_ANY;
                end
                else if (b == 8'hE0)
                begin
                    n.pend = 2'd2;
                    n.cls  = CL_A0BF;
                end
                else if (b == 8'hED)
                begin
                    n.pend = 2'd2;
                    n.cls  = CL_809F;
                end
                else if (b >= 8'hE1 && b <= 8'hEF)
                begin
                    n.pend = 2'd2;
                    n.cls  = CL_ANY;
                end
                else if (b == 8'hF0)
                begin
                    n.pend = 2'd3;
                    n.cls  = CL_90BF;
                end
                else if (b >= 8'hF1 && b <= 8'hF3)
                begin
                    n.pend = 2'd3;
                    n.cls  = CL_ANY;
                end
                else if (b == 8'hF4)
                begin
                    n.pend = 2'd3;
                    n.cls  = CL_808F;
                end
                else
                begin
                    n.bad = 1'b1;
                end
            end
            else
            begin
                case (s.cls)
                    CL_A0BF: lo = 8'hA0;
                    CL_809F: hi = 8'h9F;
                    CL_90BF: lo = 8'h90;
                    CL_808F: hi = 8'h8F;
                    default: lo = 8'h80;
                endcase
                if (b < lo || b > hi)
                begin
                    n.bad = 1'b1;
                end
                else
                begin
                    n.pend = s.pend - 2'd1;
                    n.cls  = CL_ANY;
                end
            end
        end
        return n;
    endfunction

endpackage

// ===== hdl/toml_string_unescape_top.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake          Payload
// s_*       in         s_tvalid/s_tready  s_tdata: in_byte, s_tlast: is_last
// m_*       out        m_tvalid/m_tready  m_tdata: data_byte, status; m_tuser: kind
//
// One byte per cycle; a result appears in the cycle after the byte that causes it.
// Throughput is set by the single output register: s_tready drops only while
// that register holds a result and m_tready is low.
// rst_n clears the scan state and the output valid at once; no clearing pass.
// While a result waits on a stall every byte waits, including bytes that cause none.

module toml_string_unescape_top
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [tsu_pkg::S_DATA_W-1:0]   s_tdata,   // [7:0] in_byte
    input  logic                           s_tlast,   // is_last
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [tsu_pkg::M_DATA_W-1:0]   m_tdata,   // [7:0] data_byte, [10:8] status, zero pad
    output logic [0:0]                     m_tuser    // [0] kind
);

    logic              take;
    logic              emit;
    logic              space;
    tsu_pkg::result_t  scan_res;
    tsu_pkg::result_t  out_res;

    assign s_tready = space;
    assign take     = s_tvalid && space;

    tsu_scan u_scan
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .in_byte (s_tdata[tsu_pkg::BYTE_W-1:0]),
        .is_last (s_tlast),
        .emit    (emit),
        .result  (scan_res)
    );

    tsu_out_reg u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (emit),
        .load_data (scan_res),
        .space     (space),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = {{(tsu_pkg::M_DATA_W - tsu_pkg::BYTE_W - tsu_pkg::STATUS_W){1'b0}},
                      out_res.status, out_res.data_byte};
    assign m_tuser = out_res.kind;

endmodule

// ===== hdl/tsu_scan.sv =====
`timescale 1ns / 1ps

module tsu_scan
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        take,
    input  logic [tsu_pkg::BYTE_W-1:0]  in_byte,
    input  logic                        is_last,
    output logic                        emit,
    output tsu_pkg::result_t            result
);

    logic                           inside_reg,  inside_next;
    logic                           quoted_reg,  quoted_next;
    logic [tsu_pkg::PHASE_W-1:0]    phase_reg,   phase_next;
    logic [tsu_pkg::BYTE_W-1:0]     hex_reg,     hex_next;
    logic                           hexbad_reg,  hexbad_next;
    logic [tsu_pkg::STATUS_W-1:0]   err_reg,     err_next;
    tsu_pkg::u8_state_t             u8_reg,      u8_next;

    logic                           data_emit;
    logic [tsu_pkg::BYTE_W-1:0]     data_val;
    logic [4:0]                     digit;
    logic                           hexbad_acc;
    logic [tsu_pkg::BYTE_W-1:0]     hex_acc;

    always_comb
    begin
        inside_next = inside_reg;
        quoted_next = quoted_reg;
        phase_next  = phase_reg;
        hex_next    = hex_reg;
        hexbad_next = hexbad_reg;
        err_next    = err_reg;
        u8_next     = u8_reg;
        data_emit   = 1'b0;
        data_val    = '0;
        emit        = 1'b0;
        result      = '0;
        digit       = tsu_pkg::hex_digit(in_byte);
        hexbad_acc  = hexbad_reg | digit[4]
                    | (((phase_reg == tsu_pkg::PH_HEX1) || (phase_reg == tsu_pkg::PH_HEX2))
                       && (digit != 5'd0));
        hex_acc     = {hex_reg[3:0], digit[3:0]};

        if (take)
        begin
            if (is_last)
            begin
                emit        = 1'b1;
                result.kind = 1'b1;
                if (!inside_reg || !quoted_reg || in_byte != tsu_pkg::CH_QUOTE)
                    result.status = tsu_pkg::ST_QUOTING;
                else if (err_reg != tsu_pkg::ST_OK)
                    result.status = err_reg;
                else if (phase_reg == tsu_pkg::PH_ESC)
                    result.status = tsu_pkg::ST_ESC_END;
                else if (phase_reg != tsu_pkg::PH_TEXT)
                    result.status = tsu_pkg::ST_TRUNC_U;
                else if (u8_reg.bad || u8_reg.pend != '0)
                    result.status = tsu_pkg::ST_UTF8;
                else
                    result.status = tsu_pkg::ST_OK;
                inside_next = 1'b0;
                quoted_next = 1'b0;
                phase_next  = tsu_pkg::PH_TEXT;
                hex_next    = '0;
                hexbad_next = 1'b0;
                err_next    = tsu_pkg::ST_OK;
                u8_next     = '0;
            end
            else if (!inside_reg)
            begin
                inside_next = 1'b1;
                quoted_next = (in_byte == tsu_pkg::CH_QUOTE);
            end
            else if (quoted_reg && err_reg == tsu_pkg::ST_OK)
            begin
                case (phase_reg)
                    tsu_pkg::PH_TEXT:
                    begin
                        if (in_byte == tsu_pkg::CH_QUOTE || in_byte < tsu_pkg::CH_SPACE
                            || in_byte == tsu_pkg::CH_DEL)
                            err_next = tsu_pkg::ST_UNESCAPED;
                        else if (in_byte == tsu_pkg::CH_BSL)
                            phase_next = tsu_pkg::PH_ESC;
                        else
                        begin
                            data_emit = 1'b1;
                            data_val  = in_byte;
                        end
                    end
                    tsu_pkg::PH_ESC:
                    begin
                        phase_next = tsu_pkg::PH_TEXT;
                        data_emit  = 1'b1;
                        case (in_byte)
                            8'h22: data_val = 8'h22;
                            8'h5C: data_val = 8'h5C;
                            8'h62: data_val = 8'h08;
                            8'h74: data_val = 8'h09;
                            8'h6E: data_val = 8'h0A;
                            8'h66: data_val = 8'h0C;
                            8'h72: data_val = 8'h0D;
                            8'h75:
                            begin
                                data_emit   = 1'b0;
                                phase_next  = tsu_pkg::PH_HEX1;
                                hex_next    = '0;
                                hexbad_next = 1'b0;
                            end
                            default:
                            begin
                                data_emit = 1'b0;
                                err_next  = tsu_pkg::ST_UNSUPP;
                            end
                        endcase
                    end
                    tsu_pkg::PH_HEX1, tsu_pkg::PH_HEX2, tsu_pkg::PH_HEX3:
                    begin
                        hexbad_next = hexbad_acc;
                        hex_next    = hex_acc;
                        phase_next  = phase_reg + 3'd1;
                    end
                    tsu_pkg::PH_HEX4:
                    begin
                        hex_next   = hex_acc;
                        phase_next = tsu_pkg::PH_TEXT;
                        if (hexbad_acc)
                        begin
                            hexbad_next = 1'b0;
                            err_next    = tsu_pkg::ST_NONCANON;
                        end
                        else
                        begin
                            hexbad_next = 1'b0;
                            data_emit   = 1'b1;
                            data_val    = hex_acc;
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end

            if (data_emit)
            begin
                emit             = 1'b1;
                result.kind      = 1'b0;
                result.data_byte = data_val;
                u8_next          = tsu_pkg::u8_feed(u8_reg, data_val);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_reg <= 1'b0;
            quoted_reg <= 1'b0;
            phase_reg  <= tsu_pkg::PH_TEXT;
            hex_reg    <= '0;
            hexbad_reg <= 1'b0;
            err_reg    <= tsu_pkg::ST_OK;
            u8_reg     <= '0;
        end
        else
        begin
            inside_reg <= inside_next;
            quoted_reg <= quoted_next;
            phase_reg  <= phase_next;
            hex_reg    <= hex_next;
            hexbad_reg <= hexbad_next;
            err_reg    <= err_next;
            u8_reg     <= u8_next;
        end
    end

endmodule

// ===== hdl/tsu_out_reg.sv =====
`timescale 1ns / 1ps

module tsu_out_reg
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  tsu_pkg::result_t  load_data,
    output logic              space,
    output logic              out_valid,
    input  logic              out_ready,
    output tsu_pkg::result_t  out_data
);

    logic              valid_reg, valid_next;
    tsu_pkg::result_t  data_reg;

    assign space      = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);
    assign out_valid  = valid_reg;
    assign out_data   = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // hold the request until taken
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

endmodule

// ===== hdl/tsu_checker.sv =====
`timescale 1ns / 1ps

module tsu_checker
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic                           s_tlast,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [tsu_pkg::M_DATA_W-1:0]   m_tdata,
    input  logic [0:0]                     m_tuser
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result request dropped under stall");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result payload changed under stall");

    a_verdict_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> m_tvalid && m_tuser[0])
        else $error("no verdict after last byte");

    a_verdict_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[7:0] == 8'h00)
        else $error("verdict carries a data byte");

    a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[15:8] == 8'h00)
        else $error("data result carries status or pad bits");

endmodule

bind toml_string_unescape_top tsu_checker u_tsu_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
